@@ hw/rtl/jts_pkg.sv @@
// Shared types, codes and character tables for the JSON token scanner.
package jts_pkg;

  // Scanner states; codes not listed fall back to the between-tokens behavior.
  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_LIT     = 5'd1,
    ST_STR     = 5'd2,
    ST_ESC     = 5'd3,
    ST_HEX     = 5'd4,
    ST_MINUS   = 5'd5,
    ST_ZERO    = 5'd6,
    ST_INT     = 5'd7,
    ST_FRAC0   = 5'd8,
    ST_FRAC    = 5'd9,
    ST_EXP0    = 5'd10,
    ST_EXPSIGN = 5'd11,
    ST_EXPD    = 5'd12
  } scan_state_e;

  // Token kinds
  localparam logic [3:0] TK_LBRACE = 4'd0;
  localparam logic [3:0] TK_RBRACE = 4'd1;
  localparam logic [3:0] TK_COLON  = 4'd2;
  localparam logic [3:0] TK_COMMA  = 4'd3;
  localparam logic [3:0] TK_LBRACK = 4'd4;
  localparam logic [3:0] TK_RBRACK = 4'd5;
  localparam logic [3:0] TK_STRING = 4'd6;
  localparam logic [3:0] TK_NUMBER = 4'd7;
  localparam logic [3:0] TK_BOOL   = 4'd8;
  localparam logic [3:0] TK_NULL   = 4'd9;
  localparam logic [3:0] TK_EOF    = 4'd10;

  // Error codes
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_BAD_CHAR = 4'd1;
  localparam logic [3:0] ERR_LITERAL  = 4'd2;
  localparam logic [3:0] ERR_UNTERM   = 4'd3;
  localparam logic [3:0] ERR_CTRL     = 4'd4;
  localparam logic [3:0] ERR_HEX      = 4'd5;
  localparam logic [3:0] ERR_ESCAPE   = 4'd6;
  localparam logic [3:0] ERR_MINUS    = 4'd7;
  localparam logic [3:0] ERR_FRAC     = 4'd8;
  localparam logic [3:0] ERR_EXP      = 4'd9;

  // Literal selectors
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic [7:0] CTRL_MAX  = 8'h1f;
  localparam logic [2:0] HEX_DIGITS = 3'd4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // One result word
  typedef struct packed {
    logic [3:0] kind;
    logic       done;
    logic [7:0] text;
    logic       text_valid;
    logic [3:0] err;
    logic       last;
  } result_t;

  function automatic result_t mk_result(logic [3:0] kind, logic done, logic [7:0] text,
                                        logic text_valid, logic [3:0] err);
    result_t r;
    r.kind       = kind;
    r.done       = done;
    r.text       = text_valid ? text : 8'd0;
    r.text_valid = text_valid;
    r.err        = err;
    r.last       = 1'b0;
    return r;
  endfunction

  // Character of a literal word at a position, zero past its end.
  function automatic logic [7:0] lit_char(logic [1:0] kind, logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    unique case (kind)
      LIT_FALSE: begin
        unique case (pos)
          4'd0: ch = "f";
          4'd1: ch = "a";
          4'd2: ch = "l";
          4'd3: ch = "s";
          4'd4: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      LIT_NULL: begin
        unique case (pos)
          4'd0: ch = "n";
          4'd1: ch = "u";
          4'd2: ch = "l";
          4'd3: ch = "l";
          default: ch = 8'd0;
        endcase
      end
      default: begin
        unique case (pos)
          4'd0: ch = "t";
          4'd1: ch = "r";
          4'd2: ch = "u";
          4'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_exp(logic [7:0] c);
    return (c == "e") || (c == "E");
  endfunction

endpackage

@@ hw/rtl/jts_core.sv @@
// Scanner state machine: one byte in, up to two result words out per cycle that fire_i is high.
module jts_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             eoi_i,
  output logic [1:0]       count_o,
  output jts_pkg::result_t res0_o,
  output jts_pkg::result_t res1_o
);
  import jts_pkg::*;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_TEXT,
    ACT_FAIL,
    ACT_DONE,
    ACT_FINISH,
    ACT_IDLE
  } act_e;

  scan_state_e state_q, state_d;
  logic [2:0]  hex_q, hex_d;
  logic [1:0]  lkind_q, lkind_d;
  logic [2:0]  lpos_q, lpos_d;
  logic [3:0]  err_q, err_d;

  logic [7:0]  c;
  logic        eoi;
  act_e        act;
  logic [3:0]  act_kind;
  logic [3:0]  act_code;
  scan_state_e text_next;
  logic [1:0]  lkind_eff;
  logic [7:0]  lit_want;
  logic [3:0]  lpos_next;
  logic [2:0]  hex_dec;

  // Between-tokens scan of the current byte
  logic        id_put;
  result_t     id_res;
  scan_state_e id_next;
  logic        id_lit;
  logic [1:0]  id_lkind;
  logic [3:0]  id_err;

  assign eoi = eoi_i || (byte_i == 8'd0);
  assign c   = eoi ? 8'd0 : byte_i;

  always_comb begin
    id_put   = 1'b1;
    id_res   = mk_result(TK_LBRACE, 1'b1, 8'd0, 1'b0, ERR_NONE);
    id_next  = ST_IDLE;
    id_lit   = 1'b0;
    id_lkind = LIT_TRUE;
    id_err   = ERR_NONE;
    if (eoi) begin
      id_res = mk_result(TK_EOF, 1'b1, 8'd0, 1'b0, ERR_NONE);
    end else begin
      priority case (c)
        " ", 8'h09, 8'h0a, 8'h0d: id_put = 1'b0;
        "{": id_res = mk_result(TK_LBRACE, 1'b1, 8'd0, 1'b0, ERR_NONE);
        "}": id_res = mk_result(TK_RBRACE, 1'b1, 8'd0, 1'b0, ERR_NONE);
        ":": id_res = mk_result(TK_COLON, 1'b1, 8'd0, 1'b0, ERR_NONE);
        ",": id_res = mk_result(TK_COMMA, 1'b1, 8'd0, 1'b0, ERR_NONE);
        "[": id_res = mk_result(TK_LBRACK, 1'b1, 8'd0, 1'b0, ERR_NONE);
        "]": id_res = mk_result(TK_RBRACK, 1'b1, 8'd0, 1'b0, ERR_NONE);
        "t", "f", "n": begin
          id_put   = 1'b0;
          id_lit   = 1'b1;
          id_next  = ST_LIT;
          id_lkind = (c == "t") ? LIT_TRUE : ((c == "f") ? LIT_FALSE : LIT_NULL);
        end
        "\"": begin
          id_put  = 1'b0;
          id_next = ST_STR;
        end
        "-": begin
          id_res  = mk_result(TK_NUMBER, 1'b0, c, 1'b1, ERR_NONE);
          id_next = ST_MINUS;
        end
        "0": begin
          id_res  = mk_result(TK_NUMBER, 1'b0, c, 1'b1, ERR_NONE);
          id_next = ST_ZERO;
        end
        default: begin
          if (is_digit(c)) begin
            id_res  = mk_result(TK_NUMBER, 1'b0, c, 1'b1, ERR_NONE);
            id_next = ST_INT;
          end else begin
            id_res = mk_result(TK_LBRACE, 1'b0, 8'd0, 1'b0, ERR_BAD_CHAR);
            id_err = ERR_BAD_CHAR;
          end
        end
      endcase
    end
  end

  assign lkind_eff = (lkind_q == 2'd3) ? LIT_TRUE : lkind_q;
  assign lit_want  = lit_char(lkind_eff, {1'b0, lpos_q});
  assign lpos_next = {1'b0, lpos_q} + 4'd1;
  assign hex_dec   = hex_q - 3'd1;

  // Decide what the byte does in the current state
  always_comb begin
    act       = ACT_NONE;
    act_kind  = TK_NUMBER;
    act_code  = ERR_NONE;
    text_next = ST_IDLE;
    unique case (state_q)
      ST_LIT: begin
        if (eoi || (lit_want == 8'd0) || (c != lit_want)) begin
          act      = ACT_FAIL;
          act_code = ERR_LITERAL;
        end else if (lpos_next[3] || (lit_char(lkind_eff, lpos_next) == 8'd0)) begin
          act      = ACT_DONE;
          act_kind = (lkind_eff == LIT_NULL) ? TK_NULL : TK_BOOL;
        end
      end
      ST_STR: begin
        act_kind = TK_STRING;
        if (eoi) begin
          act = ACT_FAIL; act_code = ERR_UNTERM;
        end else if (c == "\"") begin
          act = ACT_DONE;
        end else if (c == "\\") begin
          act = ACT_TEXT; text_next = ST_ESC;
        end else if (c <= CTRL_MAX) begin
          act = ACT_FAIL; act_code = ERR_CTRL;
        end else begin
          act = ACT_TEXT; text_next = ST_STR;
        end
      end
      ST_ESC: begin
        act_kind = TK_STRING;
        if (eoi) begin
          act = ACT_FAIL; act_code = ERR_ESCAPE;
        end else if (c == "\"" || c == "\\" || c == "/" || c == "b" ||
                     c == "f" || c == "n" || c == "r" || c == "t") begin
          act = ACT_TEXT; text_next = ST_STR;
        end else if (c == "u") begin
          act = ACT_TEXT; text_next = ST_HEX;
        end else begin
          act = ACT_FAIL; act_code = ERR_ESCAPE;
        end
      end
      ST_HEX: begin
        act_kind = TK_STRING;
        if (eoi || !is_hex(c)) begin
          act = ACT_FAIL; act_code = ERR_HEX;
        end else begin
          act       = ACT_TEXT;
          text_next = (hex_dec == 3'd0) ? ST_STR : ST_HEX;
        end
      end
      ST_MINUS: begin
        if (c == "0") begin
          act = ACT_TEXT; text_next = ST_ZERO;
        end else if (is_digit(c)) begin
          act = ACT_TEXT; text_next = ST_INT;
        end else begin
          act = ACT_FAIL; act_code = ERR_MINUS;
        end
      end
      ST_ZERO: begin
        if (c == ".") begin
          act = ACT_TEXT; text_next = ST_FRAC0;
        end else if (is_exp(c)) begin
          act = ACT_TEXT; text_next = ST_EXP0;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_INT: begin
        if (is_digit(c)) begin
          act = ACT_TEXT; text_next = ST_INT;
        end else if (c == ".") begin
          act = ACT_TEXT; text_next = ST_FRAC0;
        end else if (is_exp(c)) begin
          act = ACT_TEXT; text_next = ST_EXP0;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_FRAC0: begin
        if (is_digit(c)) begin
          act = ACT_TEXT; text_next = ST_FRAC;
        end else begin
          act = ACT_FAIL; act_code = ERR_FRAC;
        end
      end
      ST_FRAC: begin
        if (is_digit(c)) begin
          act = ACT_TEXT; text_next = ST_FRAC;
        end else if (is_exp(c)) begin
          act = ACT_TEXT; text_next = ST_EXP0;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_EXP0: begin
        if (c == "+" || c == "-") begin
          act = ACT_TEXT; text_next = ST_EXPSIGN;
        end else if (is_digit(c)) begin
          act = ACT_TEXT; text_next = ST_EXPD;
        end else begin
          act = ACT_FAIL; act_code = ERR_EXP;
        end
      end
      ST_EXPSIGN: begin
        if (is_digit(c)) begin
          act = ACT_TEXT; text_next = ST_EXPD;
        end else begin
          act = ACT_FAIL; act_code = ERR_EXP;
        end
      end
      ST_EXPD: begin
        if (is_digit(c)) begin
          act = ACT_TEXT; text_next = ST_EXPD;
        end else begin
          act = ACT_FINISH;
        end
      end
      default: act = ACT_IDLE;
    endcase
  end

  // Apply the action: result words and next state
  always_comb begin
    state_d = state_q;
    hex_d   = hex_q;
    lkind_d = lkind_q;
    lpos_d  = lpos_q;
    err_d   = err_q;
    count_o = 2'd0;
    res0_o  = mk_result(TK_LBRACE, 1'b0, 8'd0, 1'b0, ERR_NONE);
    res1_o  = mk_result(TK_LBRACE, 1'b0, 8'd0, 1'b0, ERR_NONE);
    if (fire_i) begin
      if (err_q != ERR_NONE) begin
        count_o = 2'd1;
        res0_o  = mk_result(TK_LBRACE, 1'b0, 8'd0, 1'b0, err_q);
      end else begin
        unique case (act)
          ACT_NONE: begin
            if (state_q == ST_LIT) lpos_d = lpos_next[2:0];
          end
          ACT_TEXT: begin
            count_o = 2'd1;
            res0_o  = mk_result(act_kind, 1'b0, c, 1'b1, ERR_NONE);
            state_d = text_next;
            if (state_q == ST_ESC) hex_d = HEX_DIGITS;
            if (state_q == ST_HEX) hex_d = hex_dec;
          end
          ACT_FAIL: begin
            count_o = 2'd1;
            res0_o  = mk_result(TK_LBRACE, 1'b0, 8'd0, 1'b0, act_code);
            err_d   = act_code;
            state_d = ST_IDLE;
          end
          ACT_DONE: begin
            count_o = 2'd1;
            res0_o  = mk_result(act_kind, 1'b1, 8'd0, 1'b0, ERR_NONE);
            state_d = ST_IDLE;
            if (state_q == ST_LIT) lpos_d = lpos_next[2:0];
          end
          ACT_FINISH, ACT_IDLE: begin
            state_d = id_next;
            if (id_lit) begin
              lkind_d = id_lkind;
              lpos_d  = 3'd1;
            end
            if (id_err != ERR_NONE) err_d = id_err;
            if (act == ACT_FINISH) begin
              res0_o  = mk_result(TK_NUMBER, 1'b1, 8'd0, 1'b0, ERR_NONE);
              res1_o  = id_res;
              count_o = id_put ? 2'd2 : 2'd1;
            end else begin
              res0_o  = id_res;
              count_o = id_put ? 2'd1 : 2'd0;
            end
          end
          default: ;
        endcase
      end
      // mark the final word of this byte
      if (count_o == 2'd2) res1_o.last = 1'b1;
      else if (count_o == 2'd1) res0_o.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hex_q   <= 3'd0;
      lkind_q <= LIT_TRUE;
      lpos_q  <= 3'd0;
      err_q   <= ERR_NONE;
    end else begin
      state_q <= state_d;
      hex_q   <= hex_d;
      lkind_q <= lkind_d;
      lpos_q  <= lpos_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ hw/rtl/jts_fifo.sv @@
// Result queue: takes up to two words per cycle, hands out one.
module jts_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  jts_pkg::result_t push0_i,
  input  jts_pkg::result_t push1_i,
  input  logic             pop_i,
  output logic             room2_o,
  output logic             valid_o,
  output jts_pkg::result_t data_o
);
  import jts_pkg::*;

  localparam logic [FIFO_AW:0] DEPTH_M2 = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= DEPTH_M2);
  assign data_o  = mem[rp_q];
  assign pop     = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q + FIFO_AW'(push_cnt_i);
    rp_d  = rp_q + FIFO_AW'(pop);
    cnt_d = cnt_q + (FIFO_AW + 1)'(push_cnt_i) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem[wp_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem[wp_q + FIFO_AW'(1)] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/json_token_scanner.sv @@
// Top level of the JSON token scanner: input register, scanner, result queue.
//
// Usage:
//   Slave channel s_axis_* carries one input byte per word: tdata holds the
//   byte, tlast flags end of input (a NUL byte does the same). Master channel
//   m_axis_* carries result words: tuser tells the token kind and flags,
//   tdata holds the text byte and error code, tlast marks the final word
//   caused by one input byte. A byte may cause zero, one or two words; two
//   happen when a number is ended by a byte that itself gives a word.
//   An accepted word passes the input register, then the result queue.
//   Throughput: one byte per cycle while the receiver keeps up; the output
//   side moves one word per cycle, so a byte that gives two words is
//   absorbed by the four-entry result queue.
//   The input register advances only when the queue has room for two words;
//   when the receiver stalls, the queue fills and s_axis_tready drops, and
//   every pending word holds until taken.
//   Reset clears the scanner to between tokens, drops any error code and
//   empties the queue. An error latches: every later byte gives one error
//   word with the same code until the next reset.
module json_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] text_byte, [11:8] error_code, [15:12] zero
  output logic [5:0]  m_axis_tuser,   // [3:0] token_kind, [4] token_done, [5] text_valid
  output logic        m_axis_tlast    // last
);
  import jts_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       fire;
  logic       room2;
  logic [1:0] res_cnt;
  result_t    res0, res1, head;

  // Scan the held byte once the queue can take both possible words
  assign fire          = in_valid_q && room2;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tlast;
    end
  end

  jts_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .eoi_i   (in_eoi_q),
    .count_o (res_cnt),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  jts_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (m_axis_tready),
    .room2_o    (room2),
    .valid_o    (m_axis_tvalid),
    .data_o     (head)
  );

  // Pack the head word onto the master channel
  assign m_axis_tdata = {4'd0, head.err, head.text};
  assign m_axis_tuser = {head.text_valid, head.done, head.kind};
  assign m_axis_tlast = head.last;

endmodule

@@ hw/rtl/jts_checker.sv @@
// Port-level checks for the JSON token scanner, bound to the top level.
module jts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [5:0]  m_axis_tuser
);

  // A stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // Error words carry no token and no text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[11:8] != 4'd0) |->
      (m_axis_tuser == 6'd0) && (m_axis_tdata[7:0] == 8'd0))
    else $error("error word with token fields set");

  // Text byte is zero unless it belongs to the token text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[5] |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("text byte set without text_valid");

  // Nothing is offered right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result word offered out of reset");

endmodule

bind json_token_scanner jts_checker u_jts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
